[design/nrgfe_pkg.sv]
// ----------------------------------------------------------------------------
// nrgfe_pkg
// Types, character codes and header helpers of the sentence field extractor.
// ----------------------------------------------------------------------------
package nrgfe_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_G      = 8'h47;

    localparam logic [39:0] RMC_HEADER_RST = 40'h474E524D43;
    localparam logic [39:0] GGA_HEADER_RST = 40'h474E474741;

    localparam logic CFG_RMC_HEADER = 1'b0;
    localparam logic CFG_GGA_HEADER = 1'b1;

    localparam logic [3:0] FID_TIME     = 4'd0;
    localparam logic [3:0] FID_NS       = 4'd2;
    localparam logic [3:0] FID_EW       = 4'd4;
    localparam logic [3:0] FID_ALTITUDE = 4'd7;
    localparam logic [3:0] FID_DONE     = 4'd8;

    localparam int unsigned TIME_CHARS = 6;
    localparam logic [3:0] COMMA_SAT   = 4'd15;
    localparam logic [3:0] COMMA_DONE  = 4'd9;
    localparam logic [3:0] COMMA_ALT   = 4'd8;

    typedef enum logic [1:0] {
        TYPE_NONE = 2'd0,
        TYPE_RMC  = 2'd1,
        TYPE_GGA  = 2'd2
    } sent_type_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic       overrun;
    } item_t;

    typedef struct packed {
        logic [3:0] field_id;
        logic [4:0] char_index;
        logic [7:0] char_value;
        logic       field_end;
    } res_t;

    // Header character 1..5, character 1 in the top byte
    function automatic logic [7:0] hdr_char(input logic [39:0] hdr, input logic [2:0] p);
        logic [7:0] ch;
        case (p)
            3'd1:    ch = hdr[39:32];
            3'd2:    ch = hdr[31:24];
            3'd3:    ch = hdr[23:16];
            3'd4:    ch = hdr[15:8];
            3'd5:    ch = hdr[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[design/nrgfe_if.sv]
// ----------------------------------------------------------------------------
// nrgfe_if
// Valid/ready channels of the sentence field extractor.
// ----------------------------------------------------------------------------
interface nrgfe_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;
    logic       overrun;

    modport source (output valid, output kind, output rx_byte, output overrun, input ready);
    modport sink (input valid, input kind, input rx_byte, input overrun, output ready);
endinterface

interface nrgfe_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] field_id;
    logic [4:0] char_index;
    logic [7:0] char_value;
    logic       field_end;

    modport source (output valid, output field_id, output char_index, output char_value,
                    output field_end, input ready);
    modport sink (input valid, input field_id, input char_index, input char_value,
                  input field_end, output ready);
endinterface

interface nrgfe_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [39:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/nrgfe_in_stage.sv]
// ----------------------------------------------------------------------------
// nrgfe_in_stage
// Input register: holds one received item until the parser takes it.
// ----------------------------------------------------------------------------
module nrgfe_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    nrgfe_item_if.sink          rx,
    input  logic                take,
    output logic                item_valid,
    output nrgfe_pkg::item_t    item
);

    logic             valid_reg;
    nrgfe_pkg::item_t item_reg;

    assign rx.ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            item_reg.kind    <= rx.kind;
            item_reg.rx_byte <= rx.rx_byte;
            item_reg.overrun <= rx.overrun;
        end
    end

endmodule

[design/nrgfe_parser.sv]
// ----------------------------------------------------------------------------
// nrgfe_parser
// Sentence state, header registers and the per-byte field extraction step.
// ----------------------------------------------------------------------------
module nrgfe_parser #(
    parameter int unsigned MAX_SENTENCE = 128,
    parameter int unsigned FIELD_MAX    = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    nrgfe_cfg_if.sink           cfg,
    input  logic                item_valid,
    input  nrgfe_pkg::item_t    item,
    input  logic                out_free,
    output logic                take,
    output logic                res_valid,
    output nrgfe_pkg::res_t     res
);

    localparam int unsigned PW = $clog2(MAX_SENTENCE + 1);
    localparam int unsigned FW = $clog2(FIELD_MAX + 1);
    localparam logic [3:0] FID_NONE_C = 4'd0;

    logic [39:0]           rmc_header_reg;
    logic [39:0]           gga_header_reg;
    logic [PW-1:0]         pos_reg, pos_next;
    logic                  in_sentence_reg, in_sentence_next;
    nrgfe_pkg::sent_type_t type_reg, type_next;
    logic [3:0]            comma_reg, comma_next;
    logic [FW-1:0]         fci_reg, fci_next;
    logic                  parse_en_reg, parse_en_next;

    logic       emit;
    logic [7:0] b;
    logic [3:0] fid;
    logic       fid_ok;
    logic [FW-1:0] limit;
    logic [3:0] nc;

    assign take      = item_valid && out_free;
    assign res_valid = take && emit;
    assign cfg.ready = 1'b1;
    assign b         = item.rx_byte;

    always_comb
    begin
        fid    = FID_NONE_C;
        fid_ok = 1'b0;
        if (type_reg == nrgfe_pkg::TYPE_RMC)
        begin
            if (comma_reg == 4'd0)
            begin
                fid    = nrgfe_pkg::FID_TIME;
                fid_ok = 1'b1;
            end
            else if (comma_reg >= 4'd2 && comma_reg <= 4'd7)
            begin
                fid    = comma_reg - 4'd1;
                fid_ok = 1'b1;
            end
        end
        else if (type_reg == nrgfe_pkg::TYPE_GGA && comma_reg == nrgfe_pkg::COMMA_ALT)
        begin
            fid    = nrgfe_pkg::FID_ALTITUDE;
            fid_ok = 1'b1;
        end
    end

    always_comb
    begin
        if (fid == nrgfe_pkg::FID_TIME)
        begin
            limit = FW'(nrgfe_pkg::TIME_CHARS);
        end
        else if (fid == nrgfe_pkg::FID_NS || fid == nrgfe_pkg::FID_EW)
        begin
            limit = FW'(1);
        end
        else
        begin
            limit = FW'(FIELD_MAX);
        end
    end

    assign nc = (comma_reg < nrgfe_pkg::COMMA_SAT) ? comma_reg + 4'd1 : nrgfe_pkg::COMMA_SAT;

    always_comb
    begin
        pos_next         = pos_reg;
        in_sentence_next = in_sentence_reg;
        type_next        = type_reg;
        comma_next       = comma_reg;
        fci_next         = fci_reg;
        parse_en_next    = parse_en_reg;
        emit             = 1'b0;
        res              = '0;
        if (item.kind)
        begin
            parse_en_next = 1'b1;
        end
        else if (item.overrun)
        begin
            parse_en_next = parse_en_reg;
        end
        else if (!parse_en_reg)
        begin
            in_sentence_next = 1'b0;
        end
        else if (b == nrgfe_pkg::CH_DOLLAR)
        begin
            in_sentence_next = 1'b1;
            pos_next         = PW'(1);
            type_next        = nrgfe_pkg::TYPE_NONE;
            comma_next       = 4'd0;
            fci_next         = '0;
        end
        else if (!in_sentence_reg)
        begin
            in_sentence_next = 1'b0;
        end
        else if (b == nrgfe_pkg::CH_CR || b == nrgfe_pkg::CH_LF
                 || pos_reg >= PW'(MAX_SENTENCE))
        begin
            in_sentence_next = 1'b0;
            pos_next         = '0;
        end
        else if (pos_reg <= PW'(5))
        begin
            pos_next = pos_reg + PW'(1);
            if (b != nrgfe_pkg::hdr_char(rmc_header_reg, pos_reg[2:0])
                && b != nrgfe_pkg::hdr_char(gga_header_reg, pos_reg[2:0]))
            begin
                in_sentence_next = 1'b0;
                pos_next         = '0;
            end
            else if (pos_reg == PW'(4))
            begin
                if (b == nrgfe_pkg::CH_M)
                begin
                    type_next = nrgfe_pkg::TYPE_RMC;
                end
                else if (b == nrgfe_pkg::CH_G)
                begin
                    type_next = nrgfe_pkg::TYPE_GGA;
                end
                else
                begin
                    in_sentence_next = 1'b0;
                    pos_next         = '0;
                end
            end
        end
        else if (pos_reg == PW'(6))
        begin
            pos_next = pos_reg + PW'(1);
        end
        else
        begin
            pos_next = pos_reg + PW'(1);
            if (b == nrgfe_pkg::CH_COMMA)
            begin
                comma_next = nc;
                fci_next   = '0;
                if (type_reg == nrgfe_pkg::TYPE_RMC && nc == nrgfe_pkg::COMMA_DONE)
                begin
                    parse_en_next    = 1'b0;
                    in_sentence_next = 1'b0;
                    pos_next         = '0;
                    emit             = 1'b1;
                    res.field_id     = nrgfe_pkg::FID_DONE;
                    res.field_end    = 1'b1;
                end
                else if (fid_ok)
                begin
                    emit          = 1'b1;
                    res.field_id  = fid;
                    res.field_end = 1'b1;
                end
            end
            else if (fid_ok && fci_reg < limit)
            begin
                emit           = 1'b1;
                res.field_id   = fid;
                res.char_index = 5'(fci_reg);
                res.char_value = b;
                fci_next       = fci_reg + FW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rmc_header_reg  <= nrgfe_pkg::RMC_HEADER_RST;
            gga_header_reg  <= nrgfe_pkg::GGA_HEADER_RST;
            pos_reg         <= '0;
            in_sentence_reg <= 1'b0;
            type_reg        <= nrgfe_pkg::TYPE_NONE;
            comma_reg       <= 4'd0;
            fci_reg         <= '0;
            parse_en_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    nrgfe_pkg::CFG_RMC_HEADER: rmc_header_reg <= cfg.data;
                    nrgfe_pkg::CFG_GGA_HEADER: gga_header_reg <= cfg.data;
                    default:                   rmc_header_reg <= rmc_header_reg;
                endcase
            end
            if (take)
            begin
                pos_reg         <= pos_next;
                in_sentence_reg <= in_sentence_next;
                type_reg        <= type_next;
                comma_reg       <= comma_next;
                fci_reg         <= fci_next;
                parse_en_reg    <= parse_en_next;
            end
        end
    end

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.field_end |-> res.char_value == 8'h00 && res.char_index == 5'd0)
        else $error("end marker carries a character");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_SENTENCE))
        else $error("sentence position past limit");

    a_fci_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fci_reg <= FW'(FIELD_MAX))
        else $error("field character index past limit");

    a_type_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_sentence_reg && pos_reg > PW'(4) |-> type_reg != nrgfe_pkg::TYPE_NONE)
        else $error("body parsed without sentence type");

    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.field_id == nrgfe_pkg::FID_DONE |=> !parse_en_reg && !in_sentence_reg)
        else $error("sentence done left parser armed");

endmodule

[design/nrgfe_out_stage.sv]
// ----------------------------------------------------------------------------
// nrgfe_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module nrgfe_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  nrgfe_pkg::res_t     res,
    output logic                out_free,
    nrgfe_res_if.source         out
);

    logic            valid_reg;
    nrgfe_pkg::res_t res_reg;

    assign out_free       = !valid_reg || out.ready;
    assign out.valid      = valid_reg;
    assign out.field_id   = res_reg.field_id;
    assign out.char_index = res_reg.char_index;
    assign out.char_value = res_reg.char_value;
    assign out.field_end  = res_reg.field_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

[design/nmea_rmc_gga_field_extractor_core.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_gga_field_extractor_core
// Extracts RMC and GGA field characters from received sentence bytes.
// ----------------------------------------------------------------------------
// One item is accepted every cycle unless a stalled result register holds
// back the parser; the input register then holds one more item. An item is
// registered on acceptance, parsed while the result register is free, and
// its result, if any, is registered in the result register, which drives
// the result channel. Header registers can be written in any cycle.
module nmea_rmc_gga_field_extractor_core #(
    parameter int unsigned MAX_SENTENCE = 128,
    parameter int unsigned FIELD_MAX    = 20
) (
    input  logic          clk,
    input  logic          rst_n,
    nrgfe_cfg_if.sink     cfg,
    nrgfe_item_if.sink    rx,
    nrgfe_res_if.source   res
);

    logic                item_valid;
    nrgfe_pkg::item_t    item;
    logic                take;
    logic                out_free;
    logic                res_valid;
    nrgfe_pkg::res_t     res_data;

    nrgfe_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    nrgfe_parser #(
        .MAX_SENTENCE (MAX_SENTENCE),
        .FIELD_MAX    (FIELD_MAX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res_data)
    );

    nrgfe_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res_data),
        .out_free (out_free),
        .out      (res)
    );

endmodule
